/* hw/rtl/pce_pkg.sv */
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types, constants and the PEC byte update for the frame engine.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int MAX_DEVICES = 16;
  localparam int DATA_BYTES  = 6;
  localparam int NUM_STAGES  = DATA_BYTES;

  localparam logic [14:0] PEC_SEED = 15'h0010;
  localparam logic [14:0] PEC_POLY = 15'h4599;

  localparam logic [1:0] REQ_SEND  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  typedef enum logic [1:0] {
    K_REJ = 2'd0,
    K_CMD = 2'd1,
    K_WR  = 2'd2,
    K_CHK = 2'd3
  } kind_t;

  // pipeline word inside the front end
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  hdr;
    logic [7:0]  code_lo;
    logic [14:0] crem;
    logic [47:0] dbytes;
    logic [14:0] drem;
    logic [15:0] rx_pec;
  } stage_t;

  // queue word between front and back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  hdr;
    logic [7:0]  code_lo;
    logic [15:0] cpec;
    logic [47:0] dbytes;
    logic [15:0] dpec;
    logic        pec_ok;
  } qent_t;

  // one byte of PEC, MSB first
  function automatic logic [14:0] pec_byte(input logic [14:0] rem, input logic [7:0] b);
    logic [14:0] r;
    logic        top;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      top = r[14];
      r   = {r[13:0], 1'b0};
      if (b[i] != top) begin
        r = r ^ PEC_POLY;
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pce_queue.sv */
// ----------------------------------------------------------------------------
// pce_queue
// Two-word queue decoupling the PEC pipeline from the byte serializer.
// ----------------------------------------------------------------------------
module pce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pce_pkg::qent_t din,
  output logic           full,
  input  logic           pop,
  output pce_pkg::qent_t dout,
  output logic           empty
);
  import pce_pkg::*;

  qent_t      mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/pce_front.sv */
// ----------------------------------------------------------------------------
// pce_front
// Accepts requests, classifies them against the chain size and runs both
// PECs through a six-stage pipeline, one byte per stage.
// ----------------------------------------------------------------------------
module pce_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [4:0]     cfg_wr_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_req_type,
  input  logic [10:0]    in_command_code,
  input  logic [3:0]     in_target_address,
  input  logic           in_broadcast,
  input  logic [47:0]    in_write_data,
  input  logic [63:0]    in_response_frame,
  output logic           q_push,
  output pce_pkg::qent_t q_din,
  input  logic           q_full
);
  import pce_pkg::*;

  logic [4:0]            dev_cnt_r;
  stage_t                st_r [NUM_STAGES];
  stage_t                st_nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_r;
  logic                  adv;
  logic                  chain_ok;
  logic                  addr_ok;
  logic                  addressed;
  logic [7:0]            hdr;
  logic [47:0]           dbytes;
  kind_t                 kind;

  assign adv      = !vld_r[NUM_STAGES-1] || !q_full;
  assign in_ready = adv;
  assign q_push   = vld_r[NUM_STAGES-1] && !q_full;

  always_comb begin
    chain_ok  = (dev_cnt_r != 5'd0) && (dev_cnt_r <= 5'(MAX_DEVICES));
    addr_ok   = chain_ok && ({1'b0, in_target_address} < dev_cnt_r);
    addressed = !((in_req_type == REQ_SEND) && in_broadcast);
    hdr       = addressed ? {1'b1, in_target_address, in_command_code[10:8]}
                          : {5'd0, in_command_code[10:8]};
    dbytes    = (in_req_type == REQ_CHECK) ? in_response_frame[63:16] : in_write_data;
    case (in_req_type)
      REQ_SEND:  kind = chain_ok ? K_CMD : K_REJ;
      REQ_WRITE: kind = addr_ok ? K_WR : K_REJ;
      REQ_CHECK: kind = addr_ok ? K_CHK : K_REJ;
      default:   kind = K_REJ;
    endcase
    st_nxt[0].kind    = kind;
    st_nxt[0].hdr     = hdr;
    st_nxt[0].code_lo = in_command_code[7:0];
    st_nxt[0].crem    = pec_byte(PEC_SEED, hdr);
    st_nxt[0].dbytes  = dbytes;
    st_nxt[0].drem    = pec_byte(PEC_SEED, dbytes[47:40]);
    st_nxt[0].rx_pec  = in_response_frame[15:0];
  end

  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    always_comb begin
      st_nxt[k]      = st_r[k-1];
      st_nxt[k].drem = pec_byte(st_r[k-1].drem, st_r[k-1].dbytes[47-8*k -: 8]);
      if (k == 1) begin
        st_nxt[k].crem = pec_byte(st_r[k-1].crem, st_r[k-1].code_lo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      dev_cnt_r <= 5'd0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
      end
      if (cfg_wr_en) begin
        dev_cnt_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    q_din.kind    = st_r[NUM_STAGES-1].kind;
    q_din.hdr     = st_r[NUM_STAGES-1].hdr;
    q_din.code_lo = st_r[NUM_STAGES-1].code_lo;
    q_din.cpec    = {st_r[NUM_STAGES-1].crem, 1'b0};
    q_din.dbytes  = st_r[NUM_STAGES-1].dbytes;
    q_din.dpec    = {st_r[NUM_STAGES-1].drem, 1'b0};
    q_din.pec_ok  = ({st_r[NUM_STAGES-1].drem, 1'b0} == st_r[NUM_STAGES-1].rx_pec);
  end

endmodule

/* hw/rtl/pce_back.sv */
// ----------------------------------------------------------------------------
// pce_back
// Serializes queued frames one byte per word into the output register and
// keeps the PEC error count.
// ----------------------------------------------------------------------------
module pce_back (
  input  logic           clk,
  input  logic           rst_n,
  input  pce_pkg::qent_t q_dout,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_frame_byte,
  output logic           out_last_byte,
  output logic           out_request_ok,
  output logic [47:0]    out_read_data,
  output logic [31:0]    out_pec_error_total
);
  import pce_pkg::*;

  logic        out_valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        ok_r, ok_nxt;
  logic [47:0] rdata_r, rdata_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        load;
  logic        bad_chk;

  assign load  = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = load && last_nxt;

  always_comb begin
    case (idx_r)
      4'd0:    byte_nxt = q_dout.hdr;
      4'd1:    byte_nxt = q_dout.code_lo;
      4'd2:    byte_nxt = q_dout.cpec[15:8];
      4'd3:    byte_nxt = q_dout.cpec[7:0];
      4'd4:    byte_nxt = q_dout.dbytes[47:40];
      4'd5:    byte_nxt = q_dout.dbytes[39:32];
      4'd6:    byte_nxt = q_dout.dbytes[31:24];
      4'd7:    byte_nxt = q_dout.dbytes[23:16];
      4'd8:    byte_nxt = q_dout.dbytes[15:8];
      4'd9:    byte_nxt = q_dout.dbytes[7:0];
      4'd10:   byte_nxt = q_dout.dpec[15:8];
      4'd11:   byte_nxt = q_dout.dpec[7:0];
      default: byte_nxt = 8'd0;
    endcase
    rdata_nxt = 48'd0;
    bad_chk   = 1'b0;
    case (q_dout.kind)
      K_REJ: begin
        byte_nxt = 8'd0;
        last_nxt = 1'b1;
        ok_nxt   = 1'b0;
      end
      K_CMD: begin
        last_nxt = (idx_r == 4'd3);
        ok_nxt   = 1'b1;
      end
      K_WR: begin
        last_nxt = (idx_r == 4'd11);
        ok_nxt   = 1'b1;
      end
      K_CHK: begin
        last_nxt  = (idx_r == 4'd3);
        ok_nxt    = q_dout.pec_ok;
        rdata_nxt = q_dout.pec_ok ? q_dout.dbytes : 48'd0;
        bad_chk   = !q_dout.pec_ok && (idx_r == 4'd0);
      end
      default: begin
        byte_nxt = 8'd0;
        last_nxt = 1'b1;
        ok_nxt   = 1'b0;
      end
    endcase
    cnt_nxt = (load && bad_chk) ? cnt_r + 32'd1 : cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_nxt ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      last_r  <= last_nxt;
      ok_r    <= ok_nxt;
      rdata_r <= rdata_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      cnt_r       <= 32'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // count register moves only when a word is loaded, so it matches the held word
  assign out_valid           = out_valid_r;
  assign out_frame_byte      = byte_r;
  assign out_last_byte       = last_r;
  assign out_request_ok      = ok_r;
  assign out_read_data       = rdata_r;
  assign out_pec_error_total = cnt_r;

endmodule

/* hw/rtl/pec15_command_frame_engine.sv */
// ----------------------------------------------------------------------------
// pec15_command_frame_engine
// Builds and checks PEC-protected battery-monitor link frames.
// ----------------------------------------------------------------------------
// A request can be taken every cycle, unless the last stage is held by a full
// queue, into a six-stage PEC pipeline (one byte per stage), which feeds a
// two-word queue; the serializer then emits one word per byte at one word per
// cycle while out_ready is high. Output words per request: 1 for a rejected
// request, 4 for a command or response check, 12 for a register write.
module pec15_command_frame_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [10:0] in_command_code,
  input  logic [3:0]  in_target_address,
  input  logic        in_broadcast,
  input  logic [47:0] in_write_data,
  input  logic [63:0] in_response_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  output logic        out_request_ok,
  output logic [47:0] out_read_data,
  output logic [31:0] out_pec_error_total
);
  import pce_pkg::*;

  qent_t q_din;
  qent_t q_dout;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  pce_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_command_code   (in_command_code),
    .in_target_address (in_target_address),
    .in_broadcast      (in_broadcast),
    .in_write_data     (in_write_data),
    .in_response_frame (in_response_frame),
    .q_push            (q_push),
    .q_din             (q_din),
    .q_full            (q_full)
  );

  pce_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  pce_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_dout              (q_dout),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_last_byte       (out_last_byte),
    .out_request_ok      (out_request_ok),
    .out_read_data       (out_read_data),
    .out_pec_error_total (out_pec_error_total)
  );

endmodule
